FILE: src/lcdn_pkg.sv
// shared types, phase codes and pin decode for the character lcd nibble bus sequencer
package lcdn_pkg;

  localparam int PhaseW = 4;
  localparam int CountW = 16;
  localparam int UnitsW = 2;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [PhaseW-1:0] PH_IDLE     = 4'd0;
  localparam logic [PhaseW-1:0] PH_HI_SETUP = 4'd1;
  localparam logic [PhaseW-1:0] PH_HI_EN    = 4'd2;
  localparam logic [PhaseW-1:0] PH_HI_HOLD  = 4'd3;
  localparam logic [PhaseW-1:0] PH_LO_SETUP = 4'd4;
  localparam logic [PhaseW-1:0] PH_LO_EN    = 4'd5;
  localparam logic [PhaseW-1:0] PH_LO_HOLD  = 4'd6;
  localparam logic [PhaseW-1:0] PH_RELEASE  = 4'd7;
  localparam logic [PhaseW-1:0] PH_P_SETUP  = 4'd8;
  localparam logic [PhaseW-1:0] PH_P_EN_A   = 4'd9;
  localparam logic [PhaseW-1:0] PH_P_EN_B   = 4'd10;
  localparam logic [PhaseW-1:0] PH_P_HOLD   = 4'd11;

  localparam logic [CountW-1:0] TICKS_RESET = 16'd1000;

  typedef struct packed {
    logic       en;
    logic       rs;
    logic       rw;
    logic [3:0] nib;
    logic       drv;
  } pins_t;

  typedef struct packed {
    pins_t pins;
    logic  ready;
    logic  dropped;
  } step_res_t;

  // delay units spent in each phase
  function automatic logic [UnitsW-1:0] units_of(input logic [PhaseW-1:0] ph);
    logic [UnitsW-1:0] u;
    if (ph >= PH_P_SETUP && ph <= PH_P_HOLD) u = 2'd2;
    else if (ph == PH_IDLE) u = 2'd0;
    else u = 2'd1;
    return u;
  endfunction

  function automatic pins_t pins_of(input logic [PhaseW-1:0] ph, input logic [7:0] byte_v,
                                    input logic sel);
    pins_t p;
    p = '0;
    unique case (ph) inside
      PH_HI_SETUP, PH_HI_EN, PH_HI_HOLD: begin
        p.drv = 1'b1;
        p.rs  = sel;
        p.nib = byte_v[7:4];
        p.en  = (ph == PH_HI_EN);
      end
      PH_LO_SETUP, PH_LO_EN, PH_LO_HOLD: begin
        p.drv = 1'b1;
        p.rs  = sel;
        p.nib = byte_v[3:0];
        p.en  = (ph == PH_LO_EN);
      end
      PH_P_SETUP, PH_P_HOLD: begin
        p.rw = 1'b1;
      end
      PH_P_EN_A, PH_P_EN_B: begin
        p.rw = 1'b1;
        p.en = 1'b1;
      end
      default: begin
        p = '0;
      end
    endcase
    return p;
  endfunction

endpackage

FILE: src/lcdn_seq_core.sv
// sequencer state and next-step logic for the lcd nibble bus
module lcdn_seq_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step_en,
  input  logic                       in_operation,
  input  logic [7:0]                 in_byte_value,
  input  logic                       in_register_select,
  input  logic                       in_nibble_only,
  input  logic                       in_skip_busy_wait,
  input  logic                       in_busy_pin,
  input  logic [lcdn_pkg::CountW-1:0] ticks_per_unit,
  output lcdn_pkg::step_res_t        res
);

  logic [lcdn_pkg::PhaseW-1:0] phase_r, phase_nxt, target;
  logic [lcdn_pkg::CountW-1:0] cnt_r, cnt_nxt, limit;
  logic [lcdn_pkg::UnitsW-1:0] left_r, left_nxt, left_dec;
  logic [7:0]                  byte_r, byte_nxt;
  logic                        sel_r, sel_nxt;
  logic                        nib_only_r, nib_only_nxt;
  logic                        skip_r, skip_nxt;
  logic                        busy_r, busy_nxt;
  logic                        adv;
  logic                        dropped;

  // a zero setting acts as one tick per unit
  assign limit = (ticks_per_unit == '0) ? lcdn_pkg::CountW'(1) : ticks_per_unit;

  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    left_nxt     = left_r;
    left_dec     = left_r;
    byte_nxt     = byte_r;
    sel_nxt      = sel_r;
    nib_only_nxt = nib_only_r;
    skip_nxt     = skip_r;
    busy_nxt     = busy_r;
    dropped      = 1'b0;
    adv          = 1'b0;
    target       = lcdn_pkg::PH_IDLE;

    if (step_en) begin
      if (in_operation == lcdn_pkg::OP_WRITE) begin
        if (phase_r == lcdn_pkg::PH_IDLE) begin
          byte_nxt     = in_byte_value;
          sel_nxt      = in_register_select;
          nib_only_nxt = in_nibble_only;
          skip_nxt     = in_skip_busy_wait;
          phase_nxt    = lcdn_pkg::PH_HI_SETUP;
          cnt_nxt      = '0;
          left_nxt     = lcdn_pkg::units_of(lcdn_pkg::PH_HI_SETUP);
        end else begin
          dropped = 1'b1;
        end
      end else if (phase_r != lcdn_pkg::PH_IDLE) begin
        if ({1'b0, cnt_r} + 17'd1 >= {1'b0, limit}) begin
          cnt_nxt  = '0;
          left_dec = (left_r != '0) ? left_r - 2'd1 : left_r;
          left_nxt = left_dec;
          adv      = (left_dec == '0);
        end else begin
          cnt_nxt = cnt_r + 16'd1;
        end
      end
    end

    if (adv) begin
      unique case (phase_r)
        lcdn_pkg::PH_HI_SETUP: target = lcdn_pkg::PH_HI_EN;
        lcdn_pkg::PH_HI_EN:    target = lcdn_pkg::PH_HI_HOLD;
        lcdn_pkg::PH_HI_HOLD: begin
          if (!nib_only_r) begin
            target = lcdn_pkg::PH_LO_SETUP;
          end else if (skip_r) begin
            target = lcdn_pkg::PH_IDLE;
          end else begin
            target   = lcdn_pkg::PH_RELEASE;
            busy_nxt = 1'b1;
          end
        end
        lcdn_pkg::PH_LO_SETUP: target = lcdn_pkg::PH_LO_EN;
        lcdn_pkg::PH_LO_EN:    target = lcdn_pkg::PH_LO_HOLD;
        lcdn_pkg::PH_LO_HOLD: begin
          if (skip_r) begin
            target = lcdn_pkg::PH_IDLE;
          end else begin
            target   = lcdn_pkg::PH_RELEASE;
            busy_nxt = 1'b1;
          end
        end
        lcdn_pkg::PH_RELEASE:  target = lcdn_pkg::PH_P_SETUP;
        lcdn_pkg::PH_P_SETUP:  target = lcdn_pkg::PH_P_EN_A;
        lcdn_pkg::PH_P_EN_A: begin
          // db7 sampled as the second enable-high phase begins
          busy_nxt = in_busy_pin;
          target   = lcdn_pkg::PH_P_EN_B;
        end
        lcdn_pkg::PH_P_EN_B:   target = lcdn_pkg::PH_P_HOLD;
        lcdn_pkg::PH_P_HOLD:   target = busy_r ? lcdn_pkg::PH_P_EN_A : lcdn_pkg::PH_IDLE;
        default:               target = lcdn_pkg::PH_IDLE;
      endcase
      phase_nxt = target;
      cnt_nxt   = '0;
      left_nxt  = lcdn_pkg::units_of(target);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= lcdn_pkg::PH_IDLE;
      cnt_r      <= '0;
      left_r     <= '0;
      byte_r     <= '0;
      sel_r      <= 1'b0;
      nib_only_r <= 1'b0;
      skip_r     <= 1'b0;
      busy_r     <= 1'b1;
    end else begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      left_r     <= left_nxt;
      byte_r     <= byte_nxt;
      sel_r      <= sel_nxt;
      nib_only_r <= nib_only_nxt;
      skip_r     <= skip_nxt;
      busy_r     <= busy_nxt;
    end
  end

  always_comb begin
    res.pins    = lcdn_pkg::pins_of(phase_nxt, byte_nxt, sel_nxt);
    res.ready   = (phase_nxt == lcdn_pkg::PH_IDLE);
    res.dropped = dropped;
  end

endmodule

FILE: src/char_lcd_nibble_bus_sequencer.sv
// top level of the character lcd nibble bus sequencer
// Usage:
//   The input channel carries tick beats (operation 0) and write beats
//   (operation 1). A write beat taken while idle latches byte, register
//   select and flags and starts the sequence: high nibble, low nibble unless
//   nibble-only, each as setup, enable-high and hold units, then release and
//   busy polling on db7 unless skipped. A write beat taken while busy is
//   ignored and its result has request_dropped set. Only tick beats advance
//   time; cfg_write_data sets the ticks in one delay unit (0 acts as 1).
//   Every input beat yields exactly one result beat with the pin levels after
//   that beat. The result is in the output register the cycle after acceptance.
//   Throughput is one beat per cycle while the receiver does not stall.
//   When the receiver stalls, the output register holds its beat and the
//   input is taken only in a cycle where that register empties or is empty.
//   Synchronous reset returns the sequencer to idle, bus released, delay unit
//   of 1000 ticks, output register empty.
module char_lcd_nibble_bus_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [7:0]  in_byte_value,
  input  logic        in_register_select,
  input  logic        in_nibble_only,
  input  logic        in_skip_busy_wait,
  input  logic        in_busy_pin,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_enable_pin,
  output logic        out_select_pin,
  output logic        out_read_pin,
  output logic [3:0]  out_nibble_pins,
  output logic        out_bus_driven,
  output logic        out_ready_res,
  output logic        out_request_dropped,
  input  logic        cfg_write_enable,
  input  logic [15:0] cfg_write_data
);

  logic [lcdn_pkg::CountW-1:0] ticks_r;
  logic                        out_valid_r;
  lcdn_pkg::step_res_t         res, res_r;
  logic                        accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= lcdn_pkg::TICKS_RESET;
    end else if (cfg_write_enable) begin
      ticks_r <= cfg_write_data;
    end
  end

  lcdn_seq_core u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .step_en            (accept),
    .in_operation       (in_operation),
    .in_byte_value      (in_byte_value),
    .in_register_select (in_register_select),
    .in_nibble_only     (in_nibble_only),
    .in_skip_busy_wait  (in_skip_busy_wait),
    .in_busy_pin        (in_busy_pin),
    .ticks_per_unit     (ticks_r),
    .res                (res)
  );

  // result register, refilled on every accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_enable_pin      = res_r.pins.en;
  assign out_select_pin      = res_r.pins.rs;
  assign out_read_pin        = res_r.pins.rw;
  assign out_nibble_pins     = res_r.pins.nib;
  assign out_bus_driven      = res_r.pins.drv;
  assign out_ready_res       = res_r.ready;
  assign out_request_dropped = res_r.dropped;

  // idle means enable low, read low and bus released
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready_res) |-> (!out_enable_pin && !out_read_pin && !out_bus_driven))
    else $error("idle result with active pins");

  // a dropped write can only happen mid-sequence
  a_drop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_request_dropped) |-> !out_ready_res)
    else $error("dropped request reported while idle");

  // never read the lcd while driving the data lines
  a_no_contention: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_read_pin && out_bus_driven))
    else $error("read strobe with bus driven");

  // released bus shows zero on the data lines
  a_released_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bus_driven) |-> (out_nibble_pins == 4'd0))
    else $error("nibble pins nonzero with bus released");

endmodule

FILE: tb/char_lcd_nibble_bus_sequencer_test.sv
// self-checking testbench for the character lcd nibble bus sequencer
module char_lcd_nibble_bus_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned PHASE_BEATS = 140;
  localparam int unsigned NUM_PHASES = 6;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       rs;
    logic       nib_only;
    logic       skip;
    logic       busy;
  } lcd_beat_t;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    lcd_beat_t           beat;
    logic [17:0]         reps;
    logic [15:0]         cfg_val;
    logic                has_exp;
    lcdn_pkg::step_res_t exp;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_operation = lcdn_pkg::OP_TICK;
  logic [7:0]  in_byte_value = 8'h00;
  logic        in_register_select = 1'b0;
  logic        in_nibble_only = 1'b0;
  logic        in_skip_busy_wait = 1'b0;
  logic        in_busy_pin = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_enable_pin;
  logic        out_select_pin;
  logic        out_read_pin;
  logic [3:0]  out_nibble_pins;
  logic        out_bus_driven;
  logic        out_ready_res;
  logic        out_request_dropped;
  logic        cfg_write_enable = 1'b0;
  logic [15:0] cfg_write_data = 16'h0000;

  // sequencer shadow state
  logic [15:0]                  seq_tpu = lcdn_pkg::TICKS_RESET;
  logic [lcdn_pkg::PhaseW-1:0]  seq_phase = lcdn_pkg::PH_IDLE;
  logic [lcdn_pkg::CountW-1:0]  seq_count = '0;
  logic [lcdn_pkg::UnitsW-1:0]  seq_units = '0;
  logic [7:0]                   seq_byte = 8'h00;
  logic                         seq_sel = 1'b0;
  logic                         seq_nibo = 1'b0;
  logic                         seq_skip = 1'b0;
  logic                         seq_busy = 1'b1;
  lcdn_pkg::pins_t              seq_pins = '0;

  lcdn_pkg::step_res_t pins_expected_q[$];
  stim_row_t           stim_tab[$];
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned bad_count = 0;
  int unsigned cycle_count = 0;
  int unsigned beat_count = 0;

  char_lcd_nibble_bus_sequencer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_byte_value       (in_byte_value),
    .in_register_select  (in_register_select),
    .in_nibble_only      (in_nibble_only),
    .in_skip_busy_wait   (in_skip_busy_wait),
    .in_busy_pin         (in_busy_pin),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_enable_pin      (out_enable_pin),
    .out_select_pin      (out_select_pin),
    .out_read_pin        (out_read_pin),
    .out_nibble_pins     (out_nibble_pins),
    .out_bus_driven      (out_bus_driven),
    .out_ready_res       (out_ready_res),
    .out_request_dropped (out_request_dropped),
    .cfg_write_enable    (cfg_write_enable),
    .cfg_write_data      (cfg_write_data)
  );

  always #5 clk = ~clk;

  function automatic void seq_enter(logic [lcdn_pkg::PhaseW-1:0] ph);
    logic [3:0] nib;
    seq_phase = ph;
    seq_count = '0;
    if (ph == lcdn_pkg::PH_IDLE) seq_units = 2'd0;
    else if (ph >= lcdn_pkg::PH_P_SETUP) seq_units = 2'd2;
    else seq_units = 2'd1;
    nib = (ph <= lcdn_pkg::PH_HI_HOLD) ? seq_byte[7:4] : seq_byte[3:0];
    seq_pins = '0;
    if (ph != lcdn_pkg::PH_IDLE && ph < lcdn_pkg::PH_RELEASE) begin
      seq_pins.drv = 1'b1;
      seq_pins.rs  = seq_sel;
      seq_pins.nib = nib;
      seq_pins.en  = (ph == lcdn_pkg::PH_HI_EN) || (ph == lcdn_pkg::PH_LO_EN);
    end else if (ph >= lcdn_pkg::PH_P_SETUP) begin
      seq_pins.rw = 1'b1;
      seq_pins.en = (ph == lcdn_pkg::PH_P_EN_A) || (ph == lcdn_pkg::PH_P_EN_B);
    end
  endfunction

  function automatic void seq_end_write();
    if (seq_skip) begin
      seq_enter(lcdn_pkg::PH_IDLE);
    end else begin
      seq_busy = 1'b1;
      seq_enter(lcdn_pkg::PH_RELEASE);
    end
  endfunction

  // pin levels after one beat, advancing the shadow state
  function automatic lcdn_pkg::step_res_t lcd_step(lcd_beat_t b);
    lcdn_pkg::step_res_t r;
    int unsigned         lim;
    int unsigned         cnt;
    r.dropped = 1'b0;
    if (b.op == lcdn_pkg::OP_WRITE) begin
      if (seq_phase == lcdn_pkg::PH_IDLE) begin
        seq_byte = b.data;
        seq_sel  = b.rs;
        seq_nibo = b.nib_only;
        seq_skip = b.skip;
        seq_enter(lcdn_pkg::PH_HI_SETUP);
      end else begin
        r.dropped = 1'b1;
      end
    end else if (seq_phase != lcdn_pkg::PH_IDLE) begin
      lim = (seq_tpu == 16'd0) ? 1 : 32'(seq_tpu);
      cnt = 32'(seq_count);
      if (cnt + 1 >= lim) begin
        seq_count = '0;
        if (seq_units != 2'd0) seq_units = seq_units - 2'd1;
        if (seq_units == 2'd0) begin
          case (seq_phase)
            lcdn_pkg::PH_HI_SETUP: seq_enter(lcdn_pkg::PH_HI_EN);
            lcdn_pkg::PH_HI_EN:    seq_enter(lcdn_pkg::PH_HI_HOLD);
            lcdn_pkg::PH_HI_HOLD: begin
              if (seq_nibo) seq_end_write();
              else seq_enter(lcdn_pkg::PH_LO_SETUP);
            end
            lcdn_pkg::PH_LO_SETUP: seq_enter(lcdn_pkg::PH_LO_EN);
            lcdn_pkg::PH_LO_EN:    seq_enter(lcdn_pkg::PH_LO_HOLD);
            lcdn_pkg::PH_LO_HOLD:  seq_end_write();
            lcdn_pkg::PH_RELEASE:  seq_enter(lcdn_pkg::PH_P_SETUP);
            lcdn_pkg::PH_P_SETUP:  seq_enter(lcdn_pkg::PH_P_EN_A);
            lcdn_pkg::PH_P_EN_A: begin
              // db7 taken from the tick that closes the first enable window
              seq_busy = b.busy;
              seq_enter(lcdn_pkg::PH_P_EN_B);
            end
            lcdn_pkg::PH_P_EN_B:   seq_enter(lcdn_pkg::PH_P_HOLD);
            lcdn_pkg::PH_P_HOLD:
              seq_enter(seq_busy ? lcdn_pkg::PH_P_EN_A : lcdn_pkg::PH_IDLE);
            default:               seq_enter(lcdn_pkg::PH_IDLE);
          endcase
        end
      end else begin
        seq_count = seq_count + 16'd1;
      end
    end
    r.pins  = seq_pins;
    r.ready = (seq_phase == lcdn_pkg::PH_IDLE);
    return r;
  endfunction

  function automatic lcd_beat_t bt(logic op, logic [7:0] d, int unsigned rs,
                                   int unsigned nibo, int unsigned sk, int unsigned bz);
    lcd_beat_t b;
    b.op = op;
    b.data = d;
    b.rs = 1'(rs);
    b.nib_only = 1'(nibo);
    b.skip = 1'(sk);
    b.busy = 1'(bz);
    return b;
  endfunction

  function automatic lcdn_pkg::step_res_t res(int unsigned en, int unsigned rs,
                                              int unsigned rw, logic [3:0] nib,
                                              int unsigned drv, int unsigned rdy,
                                              int unsigned drop);
    lcdn_pkg::step_res_t r;
    r.pins.en  = 1'(en);
    r.pins.rs  = 1'(rs);
    r.pins.rw  = 1'(rw);
    r.pins.nib = nib;
    r.pins.drv = 1'(drv);
    r.ready    = 1'(rdy);
    r.dropped  = 1'(drop);
    return r;
  endfunction

  function automatic void add_row(row_kind_t k, lcd_beat_t b, int unsigned reps,
                                  int unsigned cfgv, int unsigned chk,
                                  lcdn_pkg::step_res_t e);
    stim_row_t row;
    row.kind = k;
    row.beat = b;
    row.reps = 18'(reps);
    row.cfg_val = 16'(cfgv);
    row.has_exp = 1'(chk);
    row.exp = e;
    stim_tab.push_back(row);
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_beat(lcd_beat_t b, logic chk, lcdn_pkg::step_res_t e);
    lcdn_pkg::step_res_t pred;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_operation       <= b.op;
    in_byte_value      <= b.data;
    in_register_select <= b.rs;
    in_nibble_only     <= b.nib_only;
    in_skip_busy_wait  <= b.skip;
    in_busy_pin        <= b.busy;
    do @(posedge clk); while (!in_ready);
    pred = lcd_step(b);
    pins_expected_q.push_back(chk ? e : pred);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pins_expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_ticks(logic [15:0] v);
    wait_drained();
    repeat (3) @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= v;
    seq_tpu = v;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    lcdn_pkg::step_res_t got;
    lcdn_pkg::step_res_t want;
    cycle_count++;
    if (rst_n && out_valid && out_ready) begin
      got.pins.en  = out_enable_pin;
      got.pins.rs  = out_select_pin;
      got.pins.rw  = out_read_pin;
      got.pins.nib = out_nibble_pins;
      got.pins.drv = out_bus_driven;
      got.ready    = out_ready_res;
      got.dropped  = out_request_dropped;
      if (pins_expected_q.size() == 0) begin
        if (bad_count < 10)
          $display("beat %0d: result with nothing expected, got %b", beat_count, got);
        bad_count++;
      end else begin
        want = pins_expected_q.pop_front();
        if (got.pins.en !== want.pins.en || got.pins.rs !== want.pins.rs ||
            got.pins.rw !== want.pins.rw || got.pins.nib !== want.pins.nib ||
            got.pins.drv !== want.pins.drv || got.ready !== want.ready ||
            got.dropped !== want.dropped) begin
          if (bad_count < 10)
            $display("beat %0d: expected %b %b %b %h %b %b %b got %b %b %b %h %b %b %b",
                     beat_count, want.pins.en, want.pins.rs, want.pins.rw, want.pins.nib,
                     want.pins.drv, want.ready, want.dropped, got.pins.en, got.pins.rs,
                     got.pins.rw, got.pins.nib, got.pins.drv, got.ready, got.dropped);
          bad_count++;
        end
      end
      beat_count++;
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("char_lcd_nibble_bus_sequencer: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned unit_ticks[NUM_PHASES];
    lcd_beat_t   b;
    unit_ticks = '{1, 2, 0, 3, 4, 1};
    unit_ticks[4] = $urandom_range(5, 2);

    // reset delay unit of 1000 ticks, still in setup after a few ticks
    add_row(ROW_BEAT, bt(lcdn_pkg::OP_TICK, 8'h00, 0, 0, 0, 1), 1, 0, 1,
            res(0, 0, 0, 4'h0, 0, 1, 0));
    add_row(ROW_BEAT, bt(lcdn_pkg::OP_WRITE, 8'hFF, 1, 1, 1, 0), 1, 0, 1,
            res(0, 1, 0, 4'hF, 1, 0, 0));
    add_row(ROW_BEAT, bt(lcdn_pkg::OP_WRITE, 8'h00, 0, 0, 0, 0), 1, 0, 1,
            res(0, 1, 0, 4'hF, 1, 0, 1));
    add_row(ROW_BEAT, bt(lcdn_pkg::OP_TICK, 8'h00, 0, 0, 0, 0), 20, 0, 1,
            res(0, 1, 0, 4'hF, 1, 0, 0));
    // zero behaves as one tick per unit
    add_row(ROW_CFG, '0, 0, 0, 0, '0);
    add_row(ROW_BEAT, bt(lcdn_pkg::OP_TICK, 8'h00, 0, 0, 0, 0), 1, 0, 1,
            res(1, 1, 0, 4'hF, 1, 0, 0));
    add_row(ROW_BEAT, bt(lcdn_pkg::OP_TICK, 8'h00, 0, 0, 0, 1), 2, 0, 0, '0);
    add_row(ROW_BEAT, bt(lcdn_pkg::OP_WRITE, 8'hA5, 0, 0, 0, 1), 1, 0, 1,
            res(0, 0, 0, 4'hA, 1, 0, 0));
    add_row(ROW_BEAT, bt(lcdn_pkg::OP_TICK, 8'h00, 0, 0, 0, 0), 10, 0, 0, '0);
    // busy seen high, the poll loop runs again
    add_row(ROW_BEAT, bt(lcdn_pkg::OP_TICK, 8'h00, 0, 0, 0, 1), 1, 0, 0, '0);
    add_row(ROW_BEAT, bt(lcdn_pkg::OP_TICK, 8'h00, 0, 0, 0, 0), 4, 0, 0, '0);
    add_row(ROW_BEAT, bt(lcdn_pkg::OP_WRITE, 8'h5A, 1, 1, 1, 0), 1, 0, 0, '0);
    add_row(ROW_BEAT, bt(lcdn_pkg::OP_TICK, 8'h00, 0, 0, 0, 0), 2, 0, 0, '0);
    add_row(ROW_BEAT, bt(lcdn_pkg::OP_TICK, 8'h00, 0, 0, 0, 1), 4, 0, 0, '0);
    add_row(ROW_BEAT, bt(lcdn_pkg::OP_TICK, 8'h00, 0, 0, 0, 1), 2, 0, 1,
            res(0, 0, 0, 4'h0, 0, 1, 0));
    add_row(ROW_BEAT, bt(lcdn_pkg::OP_WRITE, 8'h3C, 1, 0, 1, 1), 1, 0, 0, '0);
    add_row(ROW_BEAT, bt(lcdn_pkg::OP_TICK, 8'h00, 0, 0, 0, 1), 6, 0, 0, '0);
    add_row(ROW_BEAT, bt(lcdn_pkg::OP_WRITE, 8'hC3, 1, 1, 0, 1), 1, 0, 0, '0);
    add_row(ROW_BEAT, bt(lcdn_pkg::OP_WRITE, 8'h5A, 0, 0, 1, 1), 1, 0, 0, '0);
    add_row(ROW_BEAT, bt(lcdn_pkg::OP_TICK, 8'h00, 0, 0, 0, 0), 30, 0, 0, '0);
    // widest delay unit, then shortened mid-sequence
    add_row(ROW_CFG, '0, 0, 65535, 0, '0);
    add_row(ROW_BEAT, bt(lcdn_pkg::OP_WRITE, 8'h81, 0, 1, 1, 0), 1, 0, 1,
            res(0, 0, 0, 4'h8, 1, 0, 0));
    add_row(ROW_BEAT, bt(lcdn_pkg::OP_TICK, 8'h00, 0, 0, 0, 0), 40, 0, 1,
            res(0, 0, 0, 4'h8, 1, 0, 0));
    add_row(ROW_CFG, '0, 0, 1, 0, '0);
    add_row(ROW_BEAT, bt(lcdn_pkg::OP_TICK, 8'h00, 0, 0, 0, 0), 1, 0, 1,
            res(1, 0, 0, 4'h8, 1, 0, 0));
    add_row(ROW_BEAT, bt(lcdn_pkg::OP_TICK, 8'h00, 0, 0, 0, 0), 2, 0, 0, '0);

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stim_tab[i]) begin
      if (stim_tab[i].kind == ROW_CFG) begin
        write_ticks(stim_tab[i].cfg_val);
      end else begin
        repeat (stim_tab[i].reps) send_beat(stim_tab[i].beat, stim_tab[i].has_exp,
                                            stim_tab[i].exp);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 66; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 66; end
        default: begin send_gap_pct = 27; recv_stall_pct = 27; end
      endcase
      write_ticks(16'(unit_ticks[p]));
      for (int i = 0; i < PHASE_BEATS; i++) begin
        // hold off until the output side has caught up
        if (i == PHASE_BEATS / 2) wait_drained();
        b = bt(lcdn_pkg::OP_TICK, 8'($urandom_range(255)), $urandom_range(1),
               $urandom_range(1), $urandom_range(1), ($urandom_range(99) < 45) ? 1 : 0);
        if (seq_phase == lcdn_pkg::PH_IDLE)
          b.op = ($urandom_range(99) < 85) ? lcdn_pkg::OP_WRITE : lcdn_pkg::OP_TICK;
        else
          b.op = ($urandom_range(99) < 7) ? lcdn_pkg::OP_WRITE : lcdn_pkg::OP_TICK;
        send_beat(b, 1'b0, '0);
      end
      // run the sequence out so the next register write lands while idle
      while (seq_phase != lcdn_pkg::PH_IDLE)
        send_beat(bt(lcdn_pkg::OP_TICK, 8'h00, 0, 0, 0, 0), 1'b0, '0);
    end

    wait_drained();
    repeat (5) @(negedge clk);
    bad_count += pins_expected_q.size();
    if (bad_count == 0) begin
      $display("char_lcd_nibble_bus_sequencer: match");
    end else begin
      $display("char_lcd_nibble_bus_sequencer: mismatch");
    end
    $finish;
  end

endmodule
